// ----- hdl/fomd_pkg.sv -----
// ----------------------------------------------------------------------------
// fomd_pkg
// Shared widths, field limits and the Q16 scale table of the order message
// decoder.
// ----------------------------------------------------------------------------
package fomd_pkg;

  localparam int WORD_W     = 64;
  localparam int BYTE_W     = 8;
  localparam int GROUP_W    = 7;
  localparam int TERM_BIT   = 7;

  localparam int MANT_IDX   = 3;
  localparam int MANT_MAX   = 3;
  localparam int SIZE_MAX   = 2;
  localparam int OID_MAX    = 5;

  localparam int WIN_BYTES  = 10;
  localparam int WIN_W      = WIN_BYTES * BYTE_W;

  localparam int MANT_W     = MANT_MAX * GROUP_W;
  localparam int SCALE_W    = 17;
  localparam int PROD_W     = MANT_W + SCALE_W;
  localparam int PRICE_W    = 37;
  localparam int SIZE_W     = 8;
  localparam int OID_W      = 32;
  localparam int TYPE_W     = 3;
  localparam int EXP_W      = 7;

  typedef logic [1:0]         scale_sel_t;
  typedef logic [MANT_W-1:0]  mant_t;
  typedef logic [WIN_W-1:0]   win_t;

  // Exponent codes that map to a valid scale
  localparam logic [EXP_W-1:0] EXP_ZERO  = 7'd0;
  localparam logic [EXP_W-1:0] EXP_MIN   = 7'd125;

  // Q16 factors for 1, 0.1, 0.01 and 0.001, rounded to nearest
  function automatic logic [SCALE_W-1:0] q16_scale(input scale_sel_t sel);
    logic [SCALE_W-1:0] s;
    case (sel)
      2'd0:    s = 17'd65536;
      2'd1:    s = 17'd6554;
      2'd2:    s = 17'd655;
      default: s = 17'd66;
    endcase
    return s;
  endfunction

endpackage

// ----- hdl/fomd_in_if.sv -----
// ----------------------------------------------------------------------------
// fomd_in_if
// Message request channel: two 64-bit words, low byte first.
// ----------------------------------------------------------------------------
interface fomd_in_if;
  import fomd_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] first_word;
  logic [WORD_W-1:0] second_word;

  modport source (output valid, output first_word, output second_word, input ready);
  modport sink   (input valid, input first_word, input second_word, output ready);

endinterface

// ----- hdl/fomd_out_if.sv -----
// ----------------------------------------------------------------------------
// fomd_out_if
// Decoded order channel.
// ----------------------------------------------------------------------------
interface fomd_out_if;
  import fomd_pkg::*;

  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] price;
  logic [SIZE_W-1:0]  size;
  logic [OID_W-1:0]   order_id;
  logic [TYPE_W-1:0]  order_type;
  logic               exponent_error;

  modport source (output valid, output price, output size, output order_id,
                  output order_type, output exponent_error, input ready);
  modport sink   (input valid, input price, input size, input order_id,
                  input order_type, input exponent_error, output ready);

endinterface

// ----- hdl/fast_order_message_decoder.sv -----
// ----------------------------------------------------------------------------
// fast_order_message_decoder
// Pipeline: a request accepted at in_ch passes through three register stages,
// the last one is the output register, before its order shows at out_ch.
// Throughput: one message per cycle; a stall at out_ch backs up the stages
// and drops in_ch.ready only once all three hold a request.
// Reset: synchronous, active low; clears the stage valid bits only.
// ----------------------------------------------------------------------------
module fast_order_message_decoder (
  input  logic       clk,
  input  logic       rst_n,
  fomd_in_if.sink    in_ch,
  fomd_out_if.source out_ch
);
  import fomd_pkg::*;

  // Whole message, byte k in bits 8k+7:8k
  logic [2*WORD_W-1:0] msg;

  // Stage advance enables: a stage loads when it is empty or moves on
  logic adv1, adv2, adv3;

  // Stage 1: exponent and mantissa
  logic               s1_v_r;
  logic               s1_err_r,  s1_err_nxt;
  scale_sel_t         s1_sel_r,  s1_sel_nxt;
  mant_t              s1_mant_r, s1_mant_nxt;
  win_t               s1_win_r,  s1_win_nxt;   // starts at the size field

  // Stage 2: price product and size
  logic               s2_v_r;
  logic               s2_err_r;
  logic [PRICE_W-1:0] s2_price_r, s2_price_nxt;
  logic [SIZE_W-1:0]  s2_size_r,  s2_size_nxt;
  win_t               s2_win_r,   s2_win_nxt;  // starts at the order ID

  // Stage 3: order ID, type, output register
  logic               s3_v_r;
  logic               s3_err_r;
  logic [PRICE_W-1:0] s3_price_r;
  logic [SIZE_W-1:0]  s3_size_r;
  logic [OID_W-1:0]   s3_oid_r,  s3_oid_nxt;
  logic [TYPE_W-1:0]  s3_type_r, s3_type_nxt;

  assign msg = {in_ch.second_word, in_ch.first_word};

  // Ready ripples back from the output register
  assign adv3 = !s3_v_r || out_ch.ready;
  assign adv2 = !s2_v_r || adv3;
  assign adv1 = !s1_v_r || adv2;
  assign in_ch.ready = adv1;

  // --------------------------------------------------------------------------
  // Stage 1: exponent check, mantissa length and value, align the window
  // --------------------------------------------------------------------------
  always_comb begin
    logic [EXP_W-1:0]  exp_bits;
    logic [BYTE_W-1:0] m0, m1, m2;
    logic [EXP_W-1:0]  neg_exp;

    exp_bits = msg[(MANT_IDX-1)*BYTE_W +: EXP_W];
    m0       = msg[MANT_IDX*BYTE_W     +: BYTE_W];
    m1       = msg[(MANT_IDX+1)*BYTE_W +: BYTE_W];
    m2       = msg[(MANT_IDX+2)*BYTE_W +: BYTE_W];
    neg_exp  = EXP_ZERO - exp_bits;

    // Exponent codes 0, -1, -2, -3 pick the scale; anything else is an error
    s1_err_nxt = !((exp_bits == EXP_ZERO) || (exp_bits >= EXP_MIN));
    s1_sel_nxt = neg_exp[1:0];

    // Mantissa ends at its stop byte or after three bytes
    if (m0[TERM_BIT]) begin
      s1_mant_nxt = MANT_W'(m0[GROUP_W-1:0]);
      s1_win_nxt  = msg[(MANT_IDX+1)*BYTE_W +: WIN_W];
    end else if (m1[TERM_BIT]) begin
      s1_mant_nxt = MANT_W'({m0[GROUP_W-1:0], m1[GROUP_W-1:0]});
      s1_win_nxt  = msg[(MANT_IDX+2)*BYTE_W +: WIN_W];
    end else begin
      s1_mant_nxt = {m0[GROUP_W-1:0], m1[GROUP_W-1:0], m2[GROUP_W-1:0]};
      s1_win_nxt  = msg[(MANT_IDX+3)*BYTE_W +: WIN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv1) begin
      s1_v_r <= in_ch.valid;
    end
  end

  // Payload holds while the stage is stalled
  always_ff @(posedge clk) begin
    if (adv1 && in_ch.valid) begin
      s1_err_r  <= s1_err_nxt;
      s1_sel_r  <= s1_sel_nxt;
      s1_mant_r <= s1_mant_nxt;
      s1_win_r  <= s1_win_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: scale the mantissa, decode size, align the window to the ID
  // --------------------------------------------------------------------------
  always_comb begin
    logic [PROD_W-1:0] prod;
    logic [BYTE_W-1:0] z0, z1;

    prod = {{SCALE_W{1'b0}}, s1_mant_r} * {{MANT_W{1'b0}}, q16_scale(s1_sel_r)};
    s2_price_nxt = s1_err_r ? '0 : prod[PRICE_W-1:0];

    z0 = s1_win_r[0      +: BYTE_W];
    z1 = s1_win_r[BYTE_W +: BYTE_W];

    // Size ends at its stop byte or after two bytes; keep the low 8 bits
    if (z0[TERM_BIT]) begin
      s2_size_nxt = SIZE_W'(z0[GROUP_W-1:0]);
      s2_win_nxt  = s1_win_r >> BYTE_W;
    end else begin
      s2_size_nxt = {z0[0], z1[GROUP_W-1:0]};
      s2_win_nxt  = s1_win_r >> (SIZE_MAX*BYTE_W);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_v_r) begin
      s2_err_r   <= s1_err_r;
      s2_price_r <= s2_price_nxt;
      s2_size_r  <= s2_size_nxt;
      s2_win_r   <= s2_win_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: order ID (up to five groups, low 32 bits kept) and type byte
  // --------------------------------------------------------------------------
  always_comb begin
    logic [OID_W-1:0]  acc;
    logic              done;
    logic [2:0]        len;
    logic [BYTE_W-1:0] b;

    acc  = '0;
    done = 1'b0;
    len  = '0;
    for (int j = 0; j < OID_MAX; j++) begin
      b = s2_win_r[j*BYTE_W +: BYTE_W];
      if (!done) begin
        acc = {acc[OID_W-GROUP_W-1:0], b[GROUP_W-1:0]};
        len = 3'(j + 1);
        if (b[TERM_BIT]) begin
          done = 1'b1;
        end
      end
    end
    s3_oid_nxt = acc;

    // Type byte follows the last ID byte
    s3_type_nxt = '0;
    for (int j = 1; j <= OID_MAX; j++) begin
      if (len == 3'(j)) begin
        s3_type_nxt = s2_win_r[j*BYTE_W +: TYPE_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && s2_v_r) begin
      s3_err_r   <= s2_err_r;
      s3_price_r <= s2_price_r;
      s3_size_r  <= s2_size_r;
      s3_oid_r   <= s3_oid_nxt;
      s3_type_r  <= s3_type_nxt;
    end
  end

  assign out_ch.valid          = s3_v_r;
  assign out_ch.price          = s3_price_r;
  assign out_ch.size           = s3_size_r;
  assign out_ch.order_id       = s3_oid_r;
  assign out_ch.order_type     = s3_type_r;
  assign out_ch.exponent_error = s3_err_r;

endmodule

// ----- hdl/fomd_checker.sv -----
// ----------------------------------------------------------------------------
// fomd_checker
// Port-level checks on the order message decoder, bound to the top level.
// ----------------------------------------------------------------------------
module fomd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [fomd_pkg::PRICE_W-1:0]  out_price,
  input logic                          out_err
);
  import fomd_pkg::*;

  // A stalled order stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("order dropped while stalled");

  // A stalled order keeps its price
  a_price_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_price))
    else $error("price changed while stalled");

  // Bad exponent forces a zero price
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_err |-> out_price == '0)
    else $error("nonzero price with exponent error");

  // Backpressure at the input only comes from a stalled output
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

endmodule

bind fast_order_message_decoder fomd_checker u_fomd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_price (out_ch.price),
  .out_err   (out_ch.exponent_error)
);
